// ===== src/rsd_pkg.sv =====
// Shared types and constants of the reservoir sampler with duplicate skipping.
// Used by every module of the block but rsd_ram; depends on nothing.

package rsd_pkg;

	localparam int MAX_SLOTS_DEF = 64;
	localparam int BATCH_MAX_DEF = 64;

	localparam int ID_W      = 64;
	localparam int DRAW_W    = 32;
	localparam int VISIT_W   = 32;
	localparam int SIZE_W    = 7;
	localparam int SLOT_W    = 6;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 104;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_RESERVOIR_SIZE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEDUP_ENABLE   = 8'd1;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_DISCARD = 2'd2,
		ACT_SKIP    = 2'd3
	} action_t;

	// control of the shared id comparator
	typedef struct packed {
		logic clr;
		logic en;
	} match_ctl_t;

endpackage

// ===== src/rsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module rsd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/rsd_match.sv =====
// Shared 64-bit id comparator with a sticky hit flag, used by every scan.
// Depends on rsd_pkg.

module rsd_match (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rsd_pkg::match_ctl_t     ctl,
	input  logic [rsd_pkg::ID_W-1:0] key,
	input  logic [rsd_pkg::ID_W-1:0] data,
	output logic                    hit
);

	logic hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clr) begin
			hit_q <= 1'b0;
		end else if (ctl.en && (data == key)) begin
			hit_q <= 1'b1;
		end
	end

	assign hit = hit_q;

endmodule

// ===== src/reservoir_sampler_dedup.sv =====
// Reservoir sampler (Algorithm R) with optional skipping of duplicate ids.
// With dedup off an entry only reads the slot it lands in. With dedup on, a single
// comparator walks the slot-id RAM and then the batch-set RAM up to its fill one entry
// per cycle, and walks the batch-set RAM once more when the entry evicts a valid id.
// The next entry is taken once the sequencer is back in idle and its result has
// moved into the output register; a stalled result port holds the sequencer.
// Depends on rsd_pkg, rsd_ram, rsd_match.

module reservoir_sampler_dedup #(
	parameter int MAX_SLOTS = rsd_pkg::MAX_SLOTS_DEF,
	parameter int BATCH_MAX = rsd_pkg::BATCH_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsd_pkg::CFG_DAT_W-1:0]     cfg_data,
	// input entries
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // entry id, random draw
	input  logic                              s_axis_tlast,  // batch_last
	// results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// slot, evicted_valid, evicted_id, visited_count, batch_overflow
	output logic [rsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic [1:0]                        m_axis_tuser   // action
);

	localparam int SIDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SCNT_W = $clog2(MAX_SLOTS + 1);
	localparam int BIDX_W = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
	localparam int BCNT_W = $clog2(BATCH_MAX + 1);
	localparam int IDX_W  = (SCNT_W > BCNT_W) ? SCNT_W : BCNT_W;
	localparam int ID_W   = rsd_pkg::ID_W;
	localparam int VW     = rsd_pkg::VISIT_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EVRD  = 8'b0000_0010,
		S_EVLD  = 8'b0000_0100,
		S_RSCAN = 8'b0000_1000,
		S_BSCAN = 8'b0001_0000,
		S_REC   = 8'b0010_0000,
		S_ESCAN = 8'b0100_0000,
		S_EREC  = 8'b1000_0000
	} state_t;

	// the result is loaded from S_EVLD, S_REC or S_EREC paths through a shared done step
	state_t                    state_q;
	logic                      done_q;
	logic [rsd_pkg::SIZE_W-1:0] size_q;
	logic                      dedup_q;
	logic [VW-1:0]             visited_q;
	logic [MAX_SLOTS-1:0]      slot_valid_q;
	logic [BCNT_W-1:0]         count_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      cmp_en_q;
	logic                      ev_valid_q;
	logic                      ovf_q;
	rsd_pkg::action_t          act_q;

	logic [ID_W-1:0]           id_q;
	logic [ID_W-1:0]           ev_id_q;
	logic [SIDX_W-1:0]         pos_q;
	logic                      last_q;

	logic                      out_valid_q;
	logic [rsd_pkg::OUT_DATA_W-1:0] out_data_q;
	rsd_pkg::action_t          out_act_q;

	logic                      accept;
	logic                      out_free;
	logic [ID_W-1:0]           in_id;
	logic [rsd_pkg::DRAW_W-1:0] in_draw;
	logic [VW-1:0]             size_eff;
	logic [VW-1:0]             size_raw;
	logic                      is_append;
	logic                      is_replace;
	logic [SIDX_W-1:0]         pos_d;
	logic                      store;
	logic                      hit;
	logic                      batch_full;
	logic [VW-1:0]             visited_next;
	logic                      ev_eff;

	logic                      slot_we;
	logic [SIDX_W-1:0]         slot_raddr;
	logic [ID_W-1:0]           slot_rdata;
	logic                      bat_we;
	logic [ID_W-1:0]           bat_wdata;
	logic [ID_W-1:0]           bat_rdata;
	rsd_pkg::match_ctl_t       mctl;
	logic [ID_W-1:0]           mkey;
	logic [ID_W-1:0]           mdata;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE) && !done_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign in_id         = s_axis_tdata[63:0];
	assign in_draw       = s_axis_tdata[95:64];

	// placement decision, taken when the entry is accepted
	always_comb begin
		size_raw = VW'(size_q);
		if (size_q == '0) begin
			size_eff = VW'(1);
		end else if (size_raw > VW'(MAX_SLOTS)) begin
			size_eff = VW'(MAX_SLOTS);
		end else begin
			size_eff = size_raw;
		end
		is_append  = visited_q < size_eff;
		is_replace = in_draw < size_eff;
		pos_d      = is_append ? visited_q[SIDX_W-1:0] : in_draw[SIDX_W-1:0];
	end

	assign store        = (act_q == rsd_pkg::ACT_APPEND) || (act_q == rsd_pkg::ACT_REPLACE);
	assign batch_full   = count_q == BCNT_W'(BATCH_MAX);
	assign ev_eff       = ev_valid_q && store;
	assign visited_next = ((act_q != rsd_pkg::ACT_SKIP) && (visited_q != '1)) ?
		visited_q + VW'(1) : visited_q;

	// memories
	assign slot_we    = done_q && out_free && store;
	assign slot_raddr = (state_q == S_EVRD) ? pos_q : idx_q[SIDX_W-1:0];

	rsd_ram #(.WIDTH(ID_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (pos_q),
		.wdata (id_q),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	assign bat_we = ((state_q == S_REC) && !hit && !batch_full) ||
		((state_q == S_EREC) && !hit && !batch_full);
	assign bat_wdata = (state_q == S_EREC) ? ev_id_q : id_q;

	rsd_ram #(.WIDTH(ID_W), .DEPTH(BATCH_MAX)) u_batch_ram (
		.clk   (clk),
		.we    (bat_we),
		.waddr (count_q[BIDX_W-1:0]),
		.wdata (bat_wdata),
		.raddr (idx_q[BIDX_W-1:0]),
		.rdata (bat_rdata)
	);

	// shared comparator; the compare follows the read issue in the next cycle
	assign mctl.clr = accept || ((state_q == S_REC) && !hit && ev_eff);
	assign mctl.en  = cmp_en_q;
	assign mkey     = (state_q == S_ESCAN) ? ev_id_q : id_q;
	assign mdata    = (state_q == S_RSCAN) ? slot_rdata : bat_rdata;

	rsd_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.key    (mkey),
		.data   (mdata),
		.hit    (hit)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			size_q       <= rsd_pkg::SIZE_RESET;
			dedup_q      <= 1'b0;
			visited_q    <= '0;
			slot_valid_q <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			cmp_en_q     <= 1'b0;
			ev_valid_q   <= 1'b0;
			ovf_q        <= 1'b0;
			act_q        <= rsd_pkg::ACT_DISCARD;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					rsd_pkg::REG_RESERVOIR_SIZE: size_q  <= cfg_data[rsd_pkg::SIZE_W-1:0];
					rsd_pkg::REG_DEDUP_ENABLE:   dedup_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (done_q && out_free) begin
				done_q      <= 1'b0;
				out_valid_q <= 1'b1;
				visited_q   <= visited_next;
				if (store) begin
					slot_valid_q[pos_q] <= 1'b1;
				end
				if (last_q) begin
					count_q <= '0;
				end
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q) inside
				S_IDLE: begin
					if (accept) begin
						ovf_q <= 1'b0;
						if (is_append) begin
							act_q <= rsd_pkg::ACT_APPEND;
						end else if (is_replace) begin
							act_q <= rsd_pkg::ACT_REPLACE;
						end else begin
							act_q <= rsd_pkg::ACT_DISCARD;
						end
						state_q <= S_EVRD;
					end
				end
				S_EVRD: begin
					state_q <= S_EVLD;
				end
				S_EVLD: begin
					ev_valid_q <= store && slot_valid_q[pos_q];
					idx_q      <= '0;
					if (dedup_q) begin
						state_q <= S_RSCAN;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RSCAN: begin
					if (idx_q != IDX_W'(MAX_SLOTS)) begin
						// only valid slots take part in the membership test
						cmp_en_q <= slot_valid_q[idx_q[SIDX_W-1:0]];
						idx_q    <= idx_q + IDX_W'(1);
					end else begin
						cmp_en_q <= 1'b0;
						idx_q    <= '0;
						state_q  <= S_BSCAN;
					end
				end
				S_BSCAN, S_ESCAN: begin
					if (idx_q != IDX_W'(count_q)) begin
						cmp_en_q <= 1'b1;
						idx_q    <= idx_q + IDX_W'(1);
					end else begin
						cmp_en_q <= 1'b0;
						idx_q    <= '0;
						state_q  <= (state_q == S_BSCAN) ? S_REC : S_EREC;
					end
				end
				S_REC: begin
					if (hit) begin
						act_q   <= rsd_pkg::ACT_SKIP;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						if (batch_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + BCNT_W'(1);
						end
						if (ev_eff) begin
							state_q <= S_ESCAN;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_EREC: begin
					if (!hit) begin
						if (batch_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + BCNT_W'(1);
						end
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// entry payload and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= in_id;
			pos_q  <= pos_d;
			last_q <= s_axis_tlast;
		end
		if (state_q == S_EVLD) begin
			ev_id_q <= slot_rdata;
		end
		if (done_q && out_free) begin
			out_act_q <= act_q;
			out_data_q[5:0]    <= store ? rsd_pkg::SLOT_W'(pos_q) : '0;
			out_data_q[6]      <= ev_eff && (act_q != rsd_pkg::ACT_SKIP);
			out_data_q[70:7]   <= (ev_eff && (act_q != rsd_pkg::ACT_SKIP)) ? ev_id_q : '0;
			out_data_q[102:71] <= visited_next;
			out_data_q[103]    <= ovf_q && (act_q != rsd_pkg::ACT_SKIP);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_act_q;

endmodule

// ===== src/rsd_checker.sv =====
// Port-level checks of the reservoir sampler, attached by bind.
// Depends on rsd_pkg and the top level reservoir_sampler_dedup.

module rsd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]                     m_axis_tuser
);

	// the sequencer is not ready right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a skipped duplicate stores nothing, evicts nothing, records nothing
	a_skip_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == rsd_pkg::ACT_SKIP) |->
		(m_axis_tdata[6:0] == 7'd0) && !m_axis_tdata[103])
		else $error("skip result carries slot, eviction or overflow");

	a_discard_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == rsd_pkg::ACT_DISCARD) |->
		(m_axis_tdata[6:0] == 7'd0))
		else $error("discard result carries slot or eviction");

endmodule

bind reservoir_sampler_dedup rsd_checker u_rsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb_reservoir_sampler_dedup.sv =====
`timescale 1ns / 1ps
// Self-checking bench for reservoir_sampler_dedup: a directed table, then random batches
// under changing size and dedup settings, checked against an in-bench sampler model.
// Depends on rsd_pkg and the reservoir_sampler_dedup RTL.

module tb_reservoir_sampler_dedup;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 300;
	localparam int PHASES         = 14;
	localparam int PHASE_ITEMS    = 90;

	typedef struct packed {
		logic [rsd_pkg::ID_W-1:0]   id;
		logic [rsd_pkg::DRAW_W-1:0] draw;
		logic                       last;
	} entry_t;

	typedef struct packed {
		rsd_pkg::action_t            act;
		logic [rsd_pkg::SLOT_W-1:0]  slot;
		logic                        ev_vld;
		logic [rsd_pkg::ID_W-1:0]    ev_id;
		logic [rsd_pkg::VISIT_W-1:0] visits;
		logic                        ovf;
	} outcome_t;

	typedef struct packed {
		logic                          is_cfg;
		logic [rsd_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [rsd_pkg::CFG_DAT_W-1:0] reg_val;
		entry_t                        ent;
		logic                          typed;
		outcome_t                      want;
	} dir_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [rsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rsd_pkg::CFG_DAT_W-1:0]  cfg_data = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [rsd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // entry id, random draw
	logic                           s_axis_tlast = 1'b0;  // batch_last
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// slot, evicted_valid, evicted_id, visited_count, batch_overflow
	logic [rsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]                     m_axis_tuser;         // action

	reservoir_sampler_dedup DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// sampler model state
	logic [rsd_pkg::SIZE_W-1:0]  cfg_size  = rsd_pkg::SIZE_RESET;
	logic                        cfg_dedup = 1'b0;
	logic [rsd_pkg::VISIT_W-1:0] mdl_visited = '0;
	logic [rsd_pkg::ID_W-1:0]    held_id  [rsd_pkg::MAX_SLOTS_DEF];
	logic                        held_vld [rsd_pkg::MAX_SLOTS_DEF];
	logic [rsd_pkg::ID_W-1:0]    seen_id  [rsd_pkg::BATCH_MAX_DEF];
	int                          seen_cnt = 0;

	outcome_t pending_outcomes[$];
	dir_row_t dir_tab[$];
	int       faults = 0;
	int       idle_cycles = 0;
	int       s_idle_pct = 0;
	int       m_idle_pct = 0;
	int       m_stall_left = 0;
	bit       calm = 1'b0;
	logic [31:0] fresh_id = '0;

	initial begin
		for (int i = 0; i < rsd_pkg::MAX_SLOTS_DEF; i++)
			held_vld[i] = 1'b0;
	end

	function automatic bit is_held(logic [rsd_pkg::ID_W-1:0] id);
		for (int i = 0; i < rsd_pkg::MAX_SLOTS_DEF; i++)
			if (held_vld[i] && held_id[i] == id)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit is_seen(logic [rsd_pkg::ID_W-1:0] id);
		for (int i = 0; i < seen_cnt && i < rsd_pkg::BATCH_MAX_DEF; i++)
			if (seen_id[i] == id)
				return 1'b1;
		return 1'b0;
	endfunction

	// returns 1 when the batch set is full and the id is dropped
	function automatic bit note_seen(logic [rsd_pkg::ID_W-1:0] id);
		if (is_seen(id))
			return 1'b0;
		if (seen_cnt >= rsd_pkg::BATCH_MAX_DEF)
			return 1'b1;
		seen_id[seen_cnt] = id;
		seen_cnt++;
		return 1'b0;
	endfunction

	function automatic outcome_t sample_entry(entry_t e);
		outcome_t    o;
		int unsigned lim;
		int unsigned pos;
		bit          keep;
		o = '0;
		lim = 32'(cfg_size);
		if (lim < 1)
			lim = 1;
		if (lim > rsd_pkg::MAX_SLOTS_DEF)
			lim = rsd_pkg::MAX_SLOTS_DEF;
		if (cfg_dedup && (is_held(e.id) || is_seen(e.id))) begin
			o.act = rsd_pkg::ACT_SKIP;
		end else begin
			keep = 1'b1;
			pos = 0;
			if (mdl_visited < lim) begin
				pos = mdl_visited;
				o.act = rsd_pkg::ACT_APPEND;
			end else if (e.draw < lim) begin
				pos = e.draw;
				o.act = rsd_pkg::ACT_REPLACE;
			end else begin
				keep = 1'b0;
				o.act = rsd_pkg::ACT_DISCARD;
			end
			if (cfg_dedup && note_seen(e.id))
				o.ovf = 1'b1;
			if (keep) begin
				if (held_vld[pos]) begin
					o.ev_vld = 1'b1;
					o.ev_id = held_id[pos];
					// evicted id joins the batch set so it stays skippable this batch
					if (cfg_dedup && note_seen(held_id[pos]))
						o.ovf = 1'b1;
				end
				held_id[pos] = e.id;
				held_vld[pos] = 1'b1;
				o.slot = pos[rsd_pkg::SLOT_W-1:0];
			end
			if (mdl_visited != '1)
				mdl_visited++;
		end
		if (e.last)
			seen_cnt = 0;
		o.visits = mdl_visited;
		return o;
	endfunction

	function automatic dir_row_t cfg_row(logic [rsd_pkg::CFG_IDX_W-1:0] idx,
			logic [rsd_pkg::CFG_DAT_W-1:0] val);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic dir_row_t item_row(logic [rsd_pkg::ID_W-1:0] id,
			logic [rsd_pkg::DRAW_W-1:0] draw, bit last);
		dir_row_t r;
		r = '0;
		r.ent.id = id;
		r.ent.draw = draw;
		r.ent.last = last;
		return r;
	endfunction

	function automatic dir_row_t known_row(logic [rsd_pkg::ID_W-1:0] id,
			logic [rsd_pkg::DRAW_W-1:0] draw, bit last, rsd_pkg::action_t act, int slot,
			bit evv, logic [rsd_pkg::ID_W-1:0] evid, int vis);
		dir_row_t r;
		r = item_row(id, draw, last);
		r.typed = 1'b1;
		r.want.act = act;
		r.want.slot = slot[rsd_pkg::SLOT_W-1:0];
		r.want.ev_vld = evv;
		r.want.ev_id = evid;
		r.want.visits = vis;
		r.want.ovf = 1'b0;
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic push_entry(entry_t e, bit typed, outcome_t want);
		outcome_t pred;
		if (!calm && $urandom_range(0, 99) < s_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {e.draw, e.id};
		s_axis_tlast <= e.last;
		do @(posedge clk); while (!s_axis_tready);
		pred = sample_entry(e);
		pending_outcomes.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [rsd_pkg::CFG_IDX_W-1:0] idx,
			logic [rsd_pkg::CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rsd_pkg::REG_RESERVOIR_SIZE)
			cfg_size = val[rsd_pkg::SIZE_W-1:0];
		else if (idx == rsd_pkg::REG_DEDUP_ENABLE)
			cfg_dedup = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending and let the block drain before touching registers
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n || calm || m_idle_pct == 0) begin
			m_axis_tready <= 1'b1;
			m_stall_left = 0;
		end else if (m_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			m_stall_left--;
		end else if ($urandom_range(0, 99) < m_idle_pct) begin
			m_axis_tready <= 1'b0;
			m_stall_left = $urandom_range(0, 10);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.act = rsd_pkg::action_t'(m_axis_tuser);
			got.slot = m_axis_tdata[5:0];
			got.ev_vld = m_axis_tdata[6];
			got.ev_id = m_axis_tdata[70:7];
			got.visits = m_axis_tdata[102:71];
			got.ovf = m_axis_tdata[103];
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result, action %0d slot %0d visited %0d",
					$time, got.act, got.slot, got.visits);
				faults++;
			end else begin
				want = pending_outcomes.pop_front();
				if (got.act != want.act) begin
					$display("%0t: action expected %0d got %0d", $time, want.act, got.act);
					faults++;
				end
				if (got.slot != want.slot) begin
					$display("%0t: slot expected %0d got %0d", $time, want.slot, got.slot);
					faults++;
				end
				if (got.ev_vld != want.ev_vld) begin
					$display("%0t: evicted_valid expected %0d got %0d", $time,
						want.ev_vld, got.ev_vld);
					faults++;
				end
				if (got.ev_id != want.ev_id) begin
					$display("%0t: evicted_id expected %h got %h", $time, want.ev_id, got.ev_id);
					faults++;
				end
				if (got.visits != want.visits) begin
					$display("%0t: visited_count expected %0d got %0d", $time,
						want.visits, got.visits);
					faults++;
				end
				if (got.ovf != want.ovf) begin
					$display("%0t: batch_overflow expected %0d got %0d", $time, want.ovf, got.ovf);
					faults++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles, %0d results outstanding",
				$time, idle_cycles, pending_outcomes.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		entry_t   e;
		outcome_t none;
		bit       long_mode;
		int       blen;
		int       sent;
		int       r;
		int unsigned sz;

		none = '0;
		// small reservoir with dedup: fill, skip a held id, discard, skip a batch id, replace
		dir_tab.push_back(cfg_row(rsd_pkg::REG_RESERVOIR_SIZE, 4));
		dir_tab.push_back(cfg_row(rsd_pkg::REG_DEDUP_ENABLE, 1));
		dir_tab.push_back(known_row(64'd5, 32'd0, 0, rsd_pkg::ACT_APPEND, 0, 0, '0, 1));
		dir_tab.push_back(known_row(64'd5, 32'd0, 0, rsd_pkg::ACT_SKIP, 0, 0, '0, 1));
		dir_tab.push_back(known_row('1, '1, 0, rsd_pkg::ACT_APPEND, 1, 0, '0, 2));
		dir_tab.push_back(known_row(64'h8000_0000_0000_0000, 32'd0, 0,
			rsd_pkg::ACT_APPEND, 2, 0, '0, 3));
		dir_tab.push_back(known_row(64'd7, 32'd0, 1, rsd_pkg::ACT_APPEND, 3, 0, '0, 4));
		dir_tab.push_back(known_row(64'd9, '1, 0, rsd_pkg::ACT_DISCARD, 0, 0, '0, 5));
		dir_tab.push_back(known_row(64'd9, 32'd0, 0, rsd_pkg::ACT_SKIP, 0, 0, '0, 5));
		dir_tab.push_back(known_row(64'd11, 32'd2, 1, rsd_pkg::ACT_REPLACE, 2, 1,
			64'h8000_0000_0000_0000, 6));
		// id evicted last batch comes back; then an id evicted in this batch is skipped
		dir_tab.push_back(item_row(64'h8000_0000_0000_0000, 32'd0, 0));
		dir_tab.push_back(item_row(64'd5, 32'd1, 1));
		dir_tab.push_back(cfg_row(rsd_pkg::REG_DEDUP_ENABLE, 0));
		dir_tab.push_back(item_row(64'd11, 32'd3, 0));
		dir_tab.push_back(item_row(64'd0, 32'd4, 1));
		// size zero behaves as one
		dir_tab.push_back(cfg_row(rsd_pkg::REG_RESERVOIR_SIZE, 0));
		dir_tab.push_back(item_row(64'd1, 32'd0, 0));
		dir_tab.push_back(item_row(64'd2, 32'd1, 1));
		// oversized setting clamps to the slot count
		dir_tab.push_back(cfg_row(rsd_pkg::REG_RESERVOIR_SIZE, 127));
		dir_tab.push_back(item_row(64'd3, 32'd63, 0));
		dir_tab.push_back(item_row(64'd4, 32'd64, 1));
		// slot above a lowered size still counts as held
		dir_tab.push_back(cfg_row(rsd_pkg::REG_RESERVOIR_SIZE, 64));
		dir_tab.push_back(cfg_row(rsd_pkg::REG_RESERVOIR_SIZE, 1));
		dir_tab.push_back(cfg_row(rsd_pkg::REG_DEDUP_ENABLE, 1));
		dir_tab.push_back(item_row(64'd3, 32'd0, 0));
		dir_tab.push_back(item_row(64'd12, 32'd0, 1));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		s_idle_pct = 20;
		m_idle_pct = 20;
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.is_cfg) begin
				settle();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				push_entry(row.ent, row.typed, row.want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			long_mode = (ph == 3 || ph == 10);
			case (ph)
				0: sz = 64;
				1: sz = 1;
				5: sz = 0;
				9: sz = 127;
				default: sz = $urandom_range(1, 64);
			endcase
			write_reg(rsd_pkg::REG_RESERVOIR_SIZE, sz);
			write_reg(rsd_pkg::REG_DEDUP_ENABLE, (long_mode || (ph % 3 != 1)) ? 1 : 0);
			calm = (ph >= PHASES - 2);
			if (calm || ph % 5 == 2) begin
				s_idle_pct = 0;
				m_idle_pct = 0;
			end else begin
				s_idle_pct = $urandom_range(5, 40);
				m_idle_pct = $urandom_range(5, 40);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				blen = long_mode ? 90 : $urandom_range(1, 20);
				for (int b = 0; b < blen; b++) begin
					if (long_mode) begin
						// distinct ids fill the batch set past its capacity
						e.id = {$urandom, fresh_id};
						fresh_id++;
					end else begin
						r = $urandom_range(0, 9);
						if (r <= 5)
							e.id = 64'($urandom_range(0, 40));
						else if (r <= 8)
							e.id = 64'd0 - 64'($urandom_range(0, 40));
						else
							e.id = {$urandom, $urandom};
					end
					r = $urandom_range(0, 9);
					if (r <= 5)
						e.draw = $urandom_range(0, mdl_visited);
					else if (r <= 7)
						e.draw = $urandom_range(0, 66);
					else if (r == 8)
						e.draw = $urandom;
					else
						e.draw = $urandom_range(0, 1) ? '1 : '0;
					e.last = (b == blen - 1) || ($urandom_range(0, 19) == 0);
					push_entry(e, 1'b0, none);
					sent++;
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
